// ----- rtl/dfpm_pkg.sv -----
// ----------------------------------------------------------------------------
// dfpm_pkg
// Types, constants and functions shared by the sector ID field parser.
// ----------------------------------------------------------------------------
package dfpm_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 11;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_TARGET_CYLINDER  = 3'd0,
    CFG_TARGET_HEAD      = 3'd1,
    CFG_TARGET_SECTOR    = 3'd2,
    CFG_SECTOR_SIZE_CODE = 3'd3,
    CFG_HEAD_4BIT        = 3'd4
  } cfg_index_e;

  localparam logic [15:0] CrcPoly  = 16'h1021;
  localparam logic [15:0] CrcSeed  = 16'hFFFF;
  localparam logic [7:0]  SyncMark = 8'hA1;

  localparam logic [7:0] SdhMask4 = 8'hEF;
  localparam logic [7:0] SdhMask3 = 8'hE7;

  localparam logic [2:0] PosIdle   = 3'd0;
  localparam logic [2:0] PosCrcLow = 3'd5;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_CRC   = 2'd1,
    ERR_IDENT = 2'd2
  } err_code_e;

  typedef struct packed {
    logic [7:0] id_byte;
    logic       field_start;
  } in_item_t;

  typedef struct packed {
    logic        id_valid;
    logic [10:0] cylinder_found;
    logic [7:0]  sdh_value;
    logic [7:0]  sector_found;
    logic        target_match;
    logic [1:0]  error_code;
  } out_item_t;

  typedef struct packed {
    logic [10:0] target_cylinder;
    logic [3:0]  target_head;
    logic [7:0]  target_sector;
    logic [1:0]  sector_size_code;
    logic        head_4bit;
  } cfg_t;

  typedef struct packed {
    logic legal;
    logic [2:0] high;
  } ident_map_t;

  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  localparam logic [15:0] CrcPreset = crc_add(CrcSeed, SyncMark);

  function automatic ident_map_t ident_to_high(input logic [7:0] ident);
    ident_map_t m;
    m.legal = 1'b1;
    case (ident)
      8'hFE:   m.high = 3'd0;
      8'hFF:   m.high = 3'd1;
      8'hFC:   m.high = 3'd2;
      8'hFD:   m.high = 3'd3;
      8'hF6:   m.high = 3'd4;
      8'hF7:   m.high = 3'd5;
      8'hF4:   m.high = 3'd6;
      8'hF5:   m.high = 3'd7;
      default: begin
        m.legal = 1'b0;
        m.high  = 3'd0;
      end
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/disk_id_field_parse_match.sv -----
// ----------------------------------------------------------------------------
// disk_id_field_parse_match
// Sector ID field parser with CRC check and target sector match.
// ----------------------------------------------------------------------------
// The input channel takes one decoded ID field byte per transaction, with
// field_start marking the IDENT byte after the sync mark. The sixth byte of
// a field (the low CRC byte) yields one result transaction on the output
// channel in the cycle after it is accepted; other bytes yield none.
// Throughput is one byte per cycle while the input does not stall, set by
// the byte-parallel CRC update between the field state and result registers.
// The input stalls only while a result waits in the output register and the
// receiver stalls; the stall follows the receiver's stall in the same cycle.
// The configuration channel is always ready; writes to indexes beyond the
// register list are ignored. Configuration is expected only while idle.
// Reset clears the byte position, loads the CRC preset that includes the
// sync mark, empties the output register and sets the targets to zero with
// a sector size code of one.
// ----------------------------------------------------------------------------
module disk_id_field_parse_match (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  dfpm_pkg::in_item_t                      in_data_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output dfpm_pkg::out_item_t                     out_data_o,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [dfpm_pkg::CfgIndexWidth-1:0]      cfg_index_i,
  input  logic [dfpm_pkg::CfgDataWidth-1:0]       cfg_data_i
);
  import dfpm_pkg::*;

  cfg_t      cfg_q, cfg_d;
  logic      accept;
  logic      res_valid;
  out_item_t res;
  logic      full_stalled;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full_stalled;
  assign accept      = in_valid_i & ~full_stalled;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TARGET_CYLINDER:  cfg_d.target_cylinder  = cfg_data_i[10:0];
        CFG_TARGET_HEAD:      cfg_d.target_head      = cfg_data_i[3:0];
        CFG_TARGET_SECTOR:    cfg_d.target_sector    = cfg_data_i[7:0];
        CFG_SECTOR_SIZE_CODE: cfg_d.sector_size_code = cfg_data_i[1:0];
        CFG_HEAD_4BIT:        cfg_d.head_4bit        = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_cylinder  <= 11'd0;
      cfg_q.target_head      <= 4'd0;
      cfg_q.target_sector    <= 8'd0;
      cfg_q.sector_size_code <= 2'd1;
      cfg_q.head_4bit        <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dfpm_field_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_data_i),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dfpm_out_reg u_out_reg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (res_valid),
    .data_i         (res),
    .full_stalled_o (full_stalled),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

endmodule

// ----- rtl/dfpm_field_parser.sv -----
// ----------------------------------------------------------------------------
// dfpm_field_parser
// Byte position tracking, byte-parallel CRC and result evaluation.
// ----------------------------------------------------------------------------
module dfpm_field_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  dfpm_pkg::in_item_t  item_i,
  input  dfpm_pkg::cfg_t      cfg_i,
  output logic                res_valid_o,
  output dfpm_pkg::out_item_t res_o
);
  import dfpm_pkg::*;

  logic [2:0]  pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  ident_q, ident_d;
  logic [7:0]  cyl_q, cyl_d;
  logic [7:0]  sdh_q, sdh_d;
  logic [7:0]  sector_q, sector_d;
  ident_map_t  imap;
  logic [10:0] cyl;
  logic [1:0]  err;
  logic [7:0]  sdh_mask, sdh_want;

  always_comb begin
    pos_d       = pos_q;
    crc_d       = crc_q;
    ident_d     = ident_q;
    cyl_d       = cyl_q;
    sdh_d       = sdh_q;
    sector_d    = sector_q;
    res_valid_o = 1'b0;
    if (accept_i) begin
      if (item_i.field_start) begin
        crc_d   = crc_add(CrcPreset, item_i.id_byte);
        ident_d = item_i.id_byte;
        pos_d   = 3'd1;
      end else if (pos_q == PosIdle || pos_q > PosCrcLow) begin
        pos_d = PosIdle;
      end else begin
        crc_d = crc_add(crc_q, item_i.id_byte);
        case (pos_q)
          3'd1:    cyl_d    = item_i.id_byte;
          3'd2:    sdh_d    = item_i.id_byte;
          3'd3:    sector_d = item_i.id_byte;
          default: ;
        endcase
        if (pos_q < PosCrcLow) begin
          pos_d = pos_q + 3'd1;
        end else begin
          pos_d       = PosIdle;
          res_valid_o = 1'b1;
        end
      end
    end
  end

  always_comb begin
    imap = ident_to_high(ident_q);
    if (crc_d != 16'h0000) begin
      err = ERR_CRC;
    end else if (!imap.legal) begin
      err = ERR_IDENT;
    end else begin
      err = ERR_NONE;
    end
    cyl      = imap.legal ? {imap.high, cyl_q} : {3'd0, cyl_q};
    sdh_mask = cfg_i.head_4bit ? SdhMask4 : SdhMask3;
    sdh_want = {1'b0, cfg_i.sector_size_code, 1'b0,
                cfg_i.head_4bit ? cfg_i.target_head : {1'b0, cfg_i.target_head[2:0]}};
    res_o.id_valid       = (err == ERR_NONE);
    res_o.cylinder_found = cyl;
    res_o.sdh_value      = sdh_q;
    res_o.sector_found   = sector_q;
    res_o.target_match   = (err == ERR_NONE) && (cyl == cfg_i.target_cylinder)
                           && ((sdh_q & sdh_mask) == sdh_want)
                           && (sector_q == cfg_i.target_sector);
    res_o.error_code     = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= PosIdle;
      crc_q    <= CrcPreset;
      ident_q  <= 8'h00;
      cyl_q    <= 8'h00;
      sdh_q    <= 8'h00;
      sector_q <= 8'h00;
    end else begin
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      ident_q  <= ident_d;
      cyl_q    <= cyl_d;
      sdh_q    <= sdh_d;
      sector_q <= sector_d;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosCrcLow)
    else $error("Byte position left the ID field range.");

  a_result_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (pos_q == PosCrcLow && !item_i.field_start))
    else $error("Result raised away from the last CRC byte.");

  a_start_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && item_i.field_start) |=> (pos_q == 3'd1))
    else $error("Field start did not open a new field.");

endmodule

// ----- rtl/dfpm_out_reg.sv -----
// ----------------------------------------------------------------------------
// dfpm_out_reg
// Result register holding one result transaction toward the receiver.
// ----------------------------------------------------------------------------
module dfpm_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  dfpm_pkg::out_item_t data_i,
  output logic                full_stalled_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dfpm_pkg::out_item_t out_data_o
);
  import dfpm_pkg::*;

  logic      valid_q, valid_d;
  out_item_t data_q;

  assign full_stalled_o = valid_q & out_stall_i;
  assign out_valid_o    = valid_q;
  assign out_data_o     = data_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !(valid_q && out_stall_i))
    else $error("A pending result was overwritten.");

endmodule
